>>> sv/irb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// irb_pkg
// types and constants shared by the bilinear resampler modules
// ----------------------------------------------------------------------------
package irb_pkg;

	localparam int MAX_WIDTH_DEF   = 256;
	localparam int MAX_HEIGHT_DEF  = 256;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam int ADDR_BITS = 3;

	localparam logic [ADDR_BITS-1:0] REG_WIDTH  = 3'd0;
	localparam logic [ADDR_BITS-1:0] REG_HEIGHT = 3'd1;
	localparam logic [ADDR_BITS-1:0] REG_XSTEP  = 3'd2;
	localparam logic [ADDR_BITS-1:0] REG_YSTEP  = 3'd3;
	localparam logic [ADDR_BITS-1:0] REG_MODE   = 3'd4;

	localparam logic [1:0] MODE_ROUND    = 2'd1;
	localparam logic [1:0] MODE_BILINEAR = 2'd2;

	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_REQUEST = 1'b1;

	typedef struct packed {
		logic        opcode;
		logic [15:0] sample_in;
		logic [11:0] dest_col;
		logic [11:0] dest_row;
	} in_item_t;

	typedef struct packed {
		logic [15:0] pixel_out;
		logic        range_error;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD0,
		ST_RD1,
		ST_RD2,
		ST_RD3,
		ST_MIX,
		ST_OUT
	} back_state_t;

endpackage
`default_nettype wire

>>> sv/irb_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// irb_front
// accepts items, computes source positions and neighbour indexes
// ----------------------------------------------------------------------------
module irb_front #(
	parameter int MAX_WIDTH  = irb_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = irb_pkg::MAX_HEIGHT_DEF,
	parameter int IDX_BITS   = 16
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_stall,
	input  wire irb_pkg::in_item_t in_data,
	input  wire [8:0]            cfg_width,
	input  wire [8:0]            cfg_height,
	input  wire [23:0]           cfg_xstep,
	input  wire [23:0]           cfg_ystep,
	input  wire [1:0]            cfg_mode,
	output logic                 q_valid,
	input  wire                  q_stall,
	output logic [4*IDX_BITS+50:0] q_data
);
	import irb_pkg::*;

	// stage 1: multiply
	logic        v_s1, op_s1;
	logic [15:0] smp_s1;
	logic [35:0] px_s1, py_s1;
	// stage 2: classify
	logic        v_s2;
	logic [4*IDX_BITS+50:0] d_s2;

	logic [31:0] w, h;
	logic [20:0] c0, r0, cr, rr;
	logic [31:0] c0c, c1c, r0c, r1c;
	logic        err;
	logic [IDX_BITS-1:0] i00, i10, i01, i11;
	logic [4*IDX_BITS+50:0] d_c;

	logic adv2, adv1;
	assign adv2 = !v_s2 || !q_stall;
	assign adv1 = !v_s1 || adv2;
	assign in_stall = !adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			op_s1  <= in_data.opcode;
			smp_s1 <= in_data.sample_in;
			px_s1  <= in_data.dest_col * cfg_xstep;
			py_s1  <= in_data.dest_row * cfg_ystep;
		end
		if (adv2) d_s2 <= d_c;
	end

	always_comb begin
		w = (32'(cfg_width) > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : 32'(cfg_width);
		h = (32'(cfg_height) > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : 32'(cfg_height);
		c0 = 21'(px_s1[35:16]);
		r0 = 21'(py_s1[35:16]);
		cr = 21'((px_s1 + 36'h8000) >> 16);
		rr = 21'((py_s1 + 36'h8000) >> 16);
		c0c = (32'(c0) > w - 1) ? w - 1 : 32'(c0);
		c1c = (32'(c0) + 1 > w - 1) ? w - 1 : 32'(c0) + 1;
		r0c = (32'(r0) > h - 1) ? h - 1 : 32'(r0);
		r1c = (32'(r0) + 1 > h - 1) ? h - 1 : 32'(r0) + 1;
		err = 1'b0;
		if (w == 0 || h == 0) begin
			err = 1'b1;
		end else if (cfg_mode == MODE_ROUND) begin
			err = (32'(cr) >= w) || (32'(rr) >= h);
			c0c = 32'(cr);
			r0c = 32'(rr);
		end else if (cfg_mode != MODE_BILINEAR) begin
			err = (32'(c0) >= w) || (32'(r0) >= h);
			c0c = 32'(c0);
			r0c = 32'(r0);
		end
		i00 = IDX_BITS'(r0c * w + c0c);
		i10 = IDX_BITS'(r0c * w + c1c);
		i01 = IDX_BITS'(r1c * w + c0c);
		i11 = IDX_BITS'(r1c * w + c1c);
		// op, bilinear, err, sample, fx, fy, indexes
		d_c = {op_s1, (cfg_mode == MODE_BILINEAR), err, smp_s1,
			px_s1[15:0], py_s1[15:0], i00, i10, i01, i11};
	end

	assign q_valid = v_s2;
	assign q_data  = d_s2;
endmodule
`default_nettype wire

>>> sv/irb_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// irb_back
// frame store, neighbour fetch and bilinear blend
// ----------------------------------------------------------------------------
module irb_back #(
	parameter int IDX_BITS = 16,
	parameter int DEPTH    = 1 << IDX_BITS
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    q_valid,
	output logic                   q_stall,
	input  wire [4*IDX_BITS+50:0]  q_data,
	output logic                   out_valid,
	input  wire                    out_stall,
	output irb_pkg::out_item_t     out_data
);
	import irb_pkg::*;

	logic [15:0] mem [DEPTH];
	logic [IDX_BITS-1:0] lp_q;
	back_state_t st_q, st_n;
	logic [4*IDX_BITS+50:0] it_q;
	logic [15:0] rd_q, a00_q, a10_q, a01_q;
	logic [IDX_BITS-1:0] raddr;
	logic [33:0] top_q, bot_q;
	logic [35:0] acc_q;
	logic ov_q;
	out_item_t od_q;

	// fields: op bil err smp(16) fx(16) fy(16) i00 i10 i01 i11
	logic q_op;
	assign q_op = q_data[4*IDX_BITS+50];

	logic bil, err;
	logic [15:0] fxv, fyv;
	logic [IDX_BITS-1:0] i10, i01, i11;
	assign bil = it_q[4*IDX_BITS+49];
	assign err = it_q[4*IDX_BITS+48];
	assign fxv = it_q[4*IDX_BITS+31 -: 16];
	assign fyv = it_q[4*IDX_BITS+15 -: 16];
	assign i10 = it_q[3*IDX_BITS-1 -: IDX_BITS];
	assign i01 = it_q[2*IDX_BITS-1 -: IDX_BITS];
	assign i11 = it_q[IDX_BITS-1 -: IDX_BITS];

	logic take;
	assign q_stall = (st_q != ST_IDLE);
	assign take = q_valid && (st_q == ST_IDLE);

	always_comb begin
		st_n = st_q;
		unique case (st_q)
			ST_IDLE: if (q_valid && q_op == OP_REQUEST) st_n = ST_RD0;
			ST_RD0:  st_n = ST_RD1;
			ST_RD1:  st_n = ST_RD2;
			ST_RD2:  st_n = ST_RD3;
			ST_RD3:  st_n = ST_MIX;
			ST_MIX:  st_n = ST_OUT;
			ST_OUT:  if (!ov_q || !out_stall) st_n = ST_IDLE;
			default: st_n = ST_IDLE;
		endcase
	end

	always_comb begin
		unique case (st_q)
			ST_RD0:  raddr = i10;
			ST_RD1:  raddr = i01;
			ST_RD2:  raddr = i11;
			default: raddr = q_data[4*IDX_BITS-1 -: IDX_BITS];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			lp_q <= '0;
			ov_q <= 1'b0;
		end else begin
			st_q <= st_n;
			if (take && q_op == OP_LOAD)
				lp_q <= (32'(lp_q) == DEPTH - 1) ? '0 : lp_q + 1'b1;
			if (st_q == ST_OUT && (!ov_q || !out_stall)) ov_q <= 1'b1;
			else if (ov_q && !out_stall) ov_q <= 1'b0;
		end
	end

	logic [16:0] wx0;
	logic [16:0] wy0;
	logic [35:0] acc;
	assign wx0 = 17'h10000 - 17'(fxv);
	assign wy0 = 17'h10000 - 17'(fyv);
	always_comb acc = 36'(top_q[33:16]) * 36'(wy0) + 36'(bot_q[33:16]) * 36'(fyv)
		+ ((36'(top_q[15:0]) * 36'(wy0) + 36'(bot_q[15:0]) * 36'(fyv)
		+ 36'h80000000) >> 16);

	always_ff @(posedge clk) begin
		rd_q <= mem[raddr];
		if (take) begin
			it_q <= q_data;
			if (q_op == OP_LOAD)
				mem[lp_q] <= q_data[4*IDX_BITS+47 -: 16];
		end
		// each read lands in rd_q in the cycle after its address
		if (st_q == ST_RD0) a00_q <= rd_q;
		if (st_q == ST_RD1) a10_q <= rd_q;
		if (st_q == ST_RD2) a01_q <= rd_q;
		if (st_q == ST_RD3) begin
			top_q <= 34'(a00_q) * 34'(wx0) + 34'(a10_q) * 34'(fxv);
			bot_q <= 34'(a01_q) * 34'(wx0) + 34'(rd_q) * 34'(fxv);
		end
		if (st_q == ST_MIX) acc_q <= acc;
		if (st_q == ST_OUT && (!ov_q || !out_stall)) begin
			if (err) od_q <= '{pixel_out: 16'd0, range_error: 1'b1};
			else if (bil) od_q <= '{pixel_out: 16'(acc_q >> 16), range_error: 1'b0};
			else od_q <= '{pixel_out: a00_q, range_error: 1'b0};
		end
	end

	assign out_valid = ov_q;
	assign out_data  = od_q;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && out_stall |=> ov_q && $stable(od_q)) else $error("result lost");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q |-> !od_q.range_error || od_q.pixel_out == 16'd0) else $error("err nonzero");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_RD0 |=> st_q == ST_RD1) else $error("seq");
endmodule
`default_nettype wire

>>> sv/image_resampler_bilinear_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// image_resampler_bilinear_top
// bilinear image scaler over a stored source plane
// ----------------------------------------------------------------------------
// The back end writes a load into the frame store while idle; a request runs
// through four reads of the frame store's single read port plus blend and
// output, while the front end multiplies and classifies the next item.
module image_resampler_bilinear_top #(
	parameter int MAX_WIDTH   = irb_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT  = irb_pkg::MAX_HEIGHT_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_stall,
	input  wire irb_pkg::in_item_t in_data,
	output logic                out_valid,
	input  wire                 out_stall,
	output irb_pkg::out_item_t  out_data,
	input  wire                 psel,
	input  wire                 penable,
	input  wire                 pwrite,
	input  wire [4:0]           paddr,
	input  wire [31:0]          pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import irb_pkg::*;

	localparam int DEPTH    = MAX_WIDTH * MAX_HEIGHT;
	localparam int IDX_BITS = $clog2(DEPTH);

	logic [8:0]  w_q, h_q;
	logic [23:0] xs_q, ys_q;
	logic [1:0]  m_q;
	logic [ADDR_BITS-1:0] ra;
	assign ra = paddr[4:2];
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= 9'd1; h_q <= 9'd1; xs_q <= '0; ys_q <= '0; m_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (ra)
				REG_WIDTH:  w_q  <= pwdata[8:0];
				REG_HEIGHT: h_q  <= pwdata[8:0];
				REG_XSTEP:  xs_q <= pwdata[23:0];
				REG_YSTEP:  ys_q <= pwdata[23:0];
				REG_MODE:   m_q  <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (ra)
			REG_WIDTH:  prdata = 32'(w_q);
			REG_HEIGHT: prdata = 32'(h_q);
			REG_XSTEP:  prdata = 32'(xs_q);
			REG_YSTEP:  prdata = 32'(ys_q);
			REG_MODE:   prdata = 32'(m_q);
			default:    prdata = '0;
		endcase
	end

	logic qv, qs;
	logic [4*IDX_BITS+50:0] qd;

	irb_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .IDX_BITS(IDX_BITS)) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .in_data,
		.cfg_width(w_q), .cfg_height(h_q), .cfg_xstep(xs_q), .cfg_ystep(ys_q),
		.cfg_mode(m_q), .q_valid(qv), .q_stall(qs), .q_data(qd)
	);

	irb_back #(.IDX_BITS(IDX_BITS), .DEPTH(DEPTH)) u_back (
		.clk, .arst_n, .q_valid(qv), .q_stall(qs), .q_data(qd),
		.out_valid, .out_stall, .out_data
	);
endmodule
`default_nettype wire

>>> dv/image_resampler_bilinear_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_resampler_bilinear_top_tb
// self-checking bench for the bilinear image scaler
// ----------------------------------------------------------------------------
// Fills the start of the frame store and keeps every plane shape within it,
// so that every later read hits written data, then sends directed and
// random load and request traffic under several idle and stall mixes. Each
// result is checked against a predictor of the floor, round and bilinear
// paths.
module image_resampler_bilinear_top_tb;
	import irb_pkg::*;

	localparam int          STORE_SIZE     = 65536;
	localparam int          FILL_COUNT     = 512;
	localparam int          CYCLE_LIMIT    = 2000000;
	localparam logic [1:0]  MODE_FLOOR     = 2'd0;
	localparam logic [1:0]  MODE_FLOOR_ALT = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_item_t    in_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_data;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	image_resampler_bilinear_top uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	// predictor state
	logic [15:0] plane [STORE_SIZE];
	int unsigned load_ptr;
	logic [8:0]  src_w, src_h;
	logic [23:0] step_x, step_y;
	logic [1:0]  mode;

	out_item_t   pixel_q [$];
	int          errors;
	int          n_loads, n_requests, n_pixels, n_range_err;
	int          gap_pct, stall_pct, hold_left;
	longint      cycles;

	function automatic longint unsigned blend(longint unsigned a00, longint unsigned a10,
			longint unsigned a01, longint unsigned a11, longint unsigned fx,
			longint unsigned fy);
		longint unsigned top, bot, hi, lo;
		top = a00 * (65536 - fx) + a10 * fx;
		bot = a01 * (65536 - fx) + a11 * fx;
		hi = (top >> 16) * (65536 - fy) + (bot >> 16) * fy;
		lo = (top & 16'hffff) * (65536 - fy) + (bot & 16'hffff) * fy;
		return (hi + ((lo + (64'd1 << 31)) >> 16)) >> 16;
	endfunction

	function automatic out_item_t resample(in_item_t req);
		out_item_t       r;
		longint unsigned w, h, px, py, c0, c1, r0, r1, col, row;
		r = '0;
		w = (src_w > 256) ? 256 : src_w;
		h = (src_h > 256) ? 256 : src_h;
		px = longint'(req.dest_col) * step_x;
		py = longint'(req.dest_row) * step_y;
		if (w == 0 || h == 0) begin
			r.range_error = 1'b1;
		end else if (mode == MODE_BILINEAR) begin
			c0 = px >> 16; r0 = py >> 16;
			c1 = c0 + 1;   r1 = r0 + 1;
			if (c0 > w - 1) c0 = w - 1;
			if (c1 > w - 1) c1 = w - 1;
			if (r0 > h - 1) r0 = h - 1;
			if (r1 > h - 1) r1 = h - 1;
			r.pixel_out = 16'(blend(plane[r0 * w + c0], plane[r0 * w + c1],
				plane[r1 * w + c0], plane[r1 * w + c1], px & 16'hffff, py & 16'hffff));
		end else begin
			if (mode == MODE_ROUND) begin
				col = (px + 16'h8000) >> 16;
				row = (py + 16'h8000) >> 16;
			end else begin
				col = px >> 16;
				row = py >> 16;
			end
			if (col >= w || row >= h)
				r.range_error = 1'b1;
			else
				r.pixel_out = plane[row * w + col];
		end
		return r;
	endfunction

	// wait for the pipe to drain so a register write cannot hit live work
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (pixel_q.size() == 0);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(logic [ADDR_BITS-1:0] idx, logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= {idx, 2'b00}; pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_WIDTH:  src_w = value[8:0];
			REG_HEIGHT: src_h = value[8:0];
			REG_XSTEP:  step_x = value[23:0];
			REG_YSTEP:  step_y = value[23:0];
			REG_MODE:   mode = value[1:0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	task automatic setup(int w, int h, int sx, int sy, logic [1:0] m);
		settle();
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		write_reg(REG_XSTEP, sx);
		write_reg(REG_YSTEP, sy);
		write_reg(REG_MODE, 32'(m));
	endtask

	task automatic send(in_item_t item);
		int gap;
		gap = 0;
		while ($urandom_range(99) < gap_pct && gap < 8) gap++;
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
			in_data <= in_item_t'({$urandom, $urandom});
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= item;
		do @(posedge clk); while (in_stall);
		if (item.opcode == OP_LOAD) begin
			plane[load_ptr] = item.sample_in;
			load_ptr = (load_ptr + 1) % STORE_SIZE;
			n_loads++;
		end else begin
			pixel_q.push_back(resample(item));
			n_requests++;
		end
	endtask

	task automatic load(logic [15:0] s);
		in_item_t it;
		it = in_item_t'({$urandom, $urandom});
		it.opcode = OP_LOAD;
		it.sample_in = s;
		send(it);
	endtask

	task automatic request(logic [11:0] c, logic [11:0] r);
		in_item_t it;
		it = in_item_t'({$urandom, $urandom});
		it.opcode = OP_REQUEST;
		it.dest_col = c;
		it.dest_row = r;
		send(it);
	endtask

	task automatic random_item(int w, int h);
		if ($urandom_range(99) < 25)
			load(16'($urandom));
		else if ($urandom_range(99) < 15)
			request(12'($urandom), 12'($urandom));
		else
			request(12'($urandom_range(w + 2)), 12'($urandom_range(h + 2)));
	endtask

	// start of the plane, every entry that any shape below can read
	task automatic test_fill_plane();
		gap_pct = 0; stall_pct = 0;
		load(16'h0000);
		load(16'hffff);
		repeat (FILL_COUNT - 2) load(16'($urandom));
	endtask

	task automatic test_directed();
		setup(32, 16, 24'hffffff, 24'hffffff, MODE_FLOOR);
		request(0, 0);
		request(4095, 4095);
		request(0, 1);
		setup(32, 16, 24'h010000, 24'h010000, MODE_FLOOR_ALT);
		request(31, 15);
		request(32, 0);
		request(0, 16);
		setup(32, 16, 24'h008000, 24'h008000, MODE_ROUND);
		request(1, 1);
		request(61, 29);
		request(63, 0);
		setup(32, 16, 24'h00c000, 24'h004000, MODE_BILINEAR);
		request(3, 5);
		request(4095, 4095);
		request(20, 50);
		setup(511, 2, 24'h018000, 24'h000001, MODE_BILINEAR);
		request(200, 4095);
		request(4095, 0);
		setup(0, 16, 24'h010000, 24'h010000, MODE_FLOOR);
		request(0, 0);
		setup(16, 0, 24'h010000, 24'h010000, MODE_BILINEAR);
		request(0, 0);
		setup(1, 1, 24'h000000, 24'h000000, MODE_ROUND);
		request(4095, 4095);
		load(16'h8001);
		setup(1, 1, 24'h000000, 24'h000000, MODE_BILINEAR);
		request(7, 9);
	endtask

	task automatic test_random(int gp, int sp);
		int w, h, m;
		gap_pct = gp; stall_pct = sp;
		repeat (4) begin
			case ($urandom_range(3))
				0: begin w = 32; h = 16; end
				1: begin w = 1; h = $urandom_range(1, 256); end
				2: begin w = $urandom_range(256, 511); h = $urandom_range(1, 2); end
				default: begin w = $urandom_range(1, 32); h = $urandom_range(1, 16); end
			endcase
			m = $urandom_range(3);
			if ($urandom_range(4) == 0)
				setup(w, h, $urandom, $urandom, 2'(m));
			else
				setup(w, h, $urandom_range(24'h020000), $urandom_range(24'h020000), 2'(m));
			repeat (35) random_item(w, h);
		end
	endtask

	task automatic test_backpressure();
		setup(32, 16, 24'h00a000, 24'h006000, MODE_BILINEAR);
		gap_pct = 0; stall_pct = 0;
		hold_left = 400;
		repeat (60) random_item(100, 100);
	endtask

	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pixel_q.size() == 0) begin
				$display("%0t: unexpected pixel, actual pixel_out=%h range_error=%b",
					$realtime, out_data.pixel_out, out_data.range_error);
				errors++;
			end else begin
				want = pixel_q.pop_front();
				n_pixels++;
				if (want.range_error) n_range_err++;
				if (out_data.pixel_out !== want.pixel_out) begin
					$display("%0t: pixel_out expected %h actual %h",
						$realtime, want.pixel_out, out_data.pixel_out);
					errors++;
				end
				if (out_data.range_error !== want.range_error) begin
					$display("%0t: range_error expected %b actual %b",
						$realtime, want.range_error, out_data.range_error);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d pixels still pending", $realtime, pixel_q.size());
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		errors = 0; n_loads = 0; n_requests = 0; n_pixels = 0; n_range_err = 0;
		gap_pct = 0; stall_pct = 0; hold_left = 0; cycles = 0;
		load_ptr = 0; src_w = 1; src_h = 1; step_x = 0; step_y = 0; mode = MODE_FLOOR;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		test_fill_plane();
		test_directed();
		test_random(0, 0);
		test_random(49, 0);
		test_random(0, 49);
		test_random(17, 17);
		test_backpressure();
		test_random(0, 0);
		@(negedge clk);
		in_valid <= 1'b0;
		wait (pixel_q.size() == 0);
		repeat (30) @(negedge clk);
		$display("covered %0d loads and %0d requests over many plane shapes",
			n_loads, n_requests);
		$display("%0d pixels checked, %0d with range errors, all sample modes",
			n_pixels, n_range_err);
		if (errors == 0 && pixel_q.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

>>> filelist.f
sv/irb_pkg.sv
sv/irb_front.sv
sv/irb_back.sv
sv/image_resampler_bilinear_top.sv
dv/image_resampler_bilinear_top_tb.sv
